/* hw/rtl/smme_pkg.sv */
package smme_pkg;

  localparam int unsigned FILE_BITS = 10;
  localparam int unsigned CHAR_BITS = 7;
  localparam int unsigned REP_BITS  = 24;
  localparam int unsigned DIGIT_BITS = 5;

  localparam logic [CHAR_BITS-1:0] CHAR_SEMI  = 7'h3B;
  localparam logic [CHAR_BITS-1:0] CHAR_COMMA = 7'h2C;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEP  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    FLD_GEN_COL = 2'd0,
    FLD_FILE    = 2'd1,
    FLD_SRC_LN  = 2'd2,
    FLD_SRC_COL = 2'd3
  } field_e;

  // base64 alphabet, index includes the continuation bit
  function automatic logic [CHAR_BITS-1:0] b64_char(input logic [DIGIT_BITS:0] idx);
    logic [CHAR_BITS-1:0] ix;
    ix = {1'b0, idx};
    if (idx < 6'd26) begin
      b64_char = ix + 7'd65;
    end else if (idx < 6'd52) begin
      b64_char = ix + 7'd71;
    end else if (idx < 6'd62) begin
      b64_char = ix - 7'd4;
    end else if (idx == 6'd62) begin
      b64_char = 7'h2B;
    end else begin
      b64_char = 7'h2F;
    end
  endfunction

endpackage

/* hw/rtl/smme_vlq.sv */
// Shared delta unit: magnitude/sign of cur - prev, then a 5-bit group shifter.
module smme_vlq #(
  parameter int unsigned OP_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [OP_BITS-1:0] cur_i,
  input  logic [OP_BITS-1:0] prev_i,
  input  logic               load_i,
  input  logic               shift_i,
  output logic [OP_BITS-1:0] diff_o,
  output logic               lt_o,
  output logic [smme_pkg::DIGIT_BITS:0] digit_o,
  output logic               more_o
);

  localparam int unsigned VBits = OP_BITS + 1;

  logic [VBits-1:0] v_q, v_d;

  assign lt_o   = cur_i < prev_i;
  assign diff_o = lt_o ? (prev_i - cur_i) : (cur_i - prev_i);

  assign more_o  = |v_q[VBits-1:smme_pkg::DIGIT_BITS];
  assign digit_o = {more_o, v_q[smme_pkg::DIGIT_BITS-1:0]};

  always_comb begin
    v_d = v_q;
    if (load_i) begin
      v_d = {diff_o, lt_o};
    end else if (shift_i) begin
      v_d = v_q >> smme_pkg::DIGIT_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

endmodule

/* hw/rtl/source_map_mapping_encoder.sv */
// Channel  | handshake                  | payload
// input    | in_valid_i / in_stall_o    | start_new_i, gen_line_i, gen_column_i,
//          |                            | src_file_i, src_line_i, src_column_i
// output   | out_valid_o / out_stall_i  | out_char_o, repeat_count_o, last_char_o
//
// One mapping runs from acceptance through a separator decision, a load of the shared
// unit for each field, one emitted character per VLQ group and a closing state before
// the next acceptance. At default widths a mapping has 4 to 16 VLQ characters; a
// separator goes out from the decision state without a state of its own.
// The shared delta/shift unit handles one VLQ group per cycle unless the output
// stalls. in_stall_o is high whenever the sequencer is not idle, through the closing
// state after the last character; rst_ni clears the previous values and sets the
// first-mapping flag. A stalled output holds the sequencer.
module source_map_mapping_encoder #(
  parameter int unsigned LINE_BITS   = 24,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   start_new_i,
  input  logic [LINE_BITS-1:0]   gen_line_i,
  input  logic [COLUMN_BITS-1:0] gen_column_i,
  input  logic [smme_pkg::FILE_BITS-1:0] src_file_i,
  input  logic [LINE_BITS-1:0]   src_line_i,
  input  logic [COLUMN_BITS-1:0] src_column_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [smme_pkg::CHAR_BITS-1:0] out_char_o,
  output logic [smme_pkg::REP_BITS-1:0]  repeat_count_o,
  output logic                   last_char_o
);

  localparam int unsigned MaxLc  = (LINE_BITS > COLUMN_BITS) ? LINE_BITS : COLUMN_BITS;
  localparam int unsigned OpBits = (MaxLc > smme_pkg::FILE_BITS) ? MaxLc
                                                                 : smme_pkg::FILE_BITS;

  smme_pkg::state_e state_q, state_d;
  smme_pkg::field_e fld_q, fld_d;

  logic [LINE_BITS-1:0]   gline_q, gline_d, sline_q, sline_d;
  logic [COLUMN_BITS-1:0] gcol_q, gcol_d, scol_q, scol_d;
  logic [smme_pkg::FILE_BITS-1:0] file_q, file_d;

  logic [LINE_BITS-1:0]   p_gline_q, p_gline_d, p_sline_q, p_sline_d;
  logic [COLUMN_BITS-1:0] p_gcol_q, p_gcol_d, p_scol_q, p_scol_d;
  logic [smme_pkg::FILE_BITS-1:0] p_file_q, p_file_d;
  logic first_q, first_d;

  logic                          ovalid_q, ovalid_d;
  logic [smme_pkg::CHAR_BITS-1:0] ochar_q, ochar_d;
  logic [smme_pkg::REP_BITS-1:0]  orep_q, orep_d;
  logic                          olast_q, olast_d;

  logic [OpBits-1:0] op_cur, op_prev, diff;
  logic              lt, more, load, shift;
  logic [smme_pkg::DIGIT_BITS:0] digit;
  logic [OpBits+smme_pkg::REP_BITS-1:0] diff_ext;

  logic accept, out_free, emit;

  smme_vlq #(
    .OP_BITS(OpBits)
  ) u_vlq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cur_i   (op_cur),
    .prev_i  (op_prev),
    .load_i  (load),
    .shift_i (shift),
    .diff_o  (diff),
    .lt_o    (lt),
    .digit_o (digit),
    .more_o  (more)
  );

  assign in_stall_o = (state_q != smme_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign diff_ext   = {{smme_pkg::REP_BITS{1'b0}}, diff};

  // operand select for the shared unit
  always_comb begin
    op_cur  = '0;
    op_prev = '0;
    if (state_q == smme_pkg::ST_SEP) begin
      op_cur  = OpBits'(gline_q);
      op_prev = OpBits'(p_gline_q);
    end else begin
      unique case (fld_q)
        smme_pkg::FLD_GEN_COL: begin
          op_cur  = OpBits'(gcol_q);
          op_prev = OpBits'(p_gcol_q);
        end
        smme_pkg::FLD_FILE: begin
          op_cur  = OpBits'(file_q);
          op_prev = OpBits'(p_file_q);
        end
        smme_pkg::FLD_SRC_LN: begin
          op_cur  = OpBits'(sline_q);
          op_prev = OpBits'(p_sline_q);
        end
        smme_pkg::FLD_SRC_COL: begin
          op_cur  = OpBits'(scol_q);
          op_prev = OpBits'(p_scol_q);
        end
        default: begin
          op_cur  = '0;
          op_prev = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    fld_d     = fld_q;
    gline_d   = gline_q;
    gcol_d    = gcol_q;
    file_d    = file_q;
    sline_d   = sline_q;
    scol_d    = scol_q;
    p_gline_d = p_gline_q;
    p_gcol_d  = p_gcol_q;
    p_file_d  = p_file_q;
    p_sline_d = p_sline_q;
    p_scol_d  = p_scol_q;
    first_d   = first_q;
    ochar_d   = ochar_q;
    orep_d    = orep_q;
    olast_d   = olast_q;
    emit      = 1'b0;
    load      = 1'b0;
    shift     = 1'b0;

    unique case (state_q)
      smme_pkg::ST_IDLE: begin
        if (accept) begin
          gline_d = gen_line_i;
          gcol_d  = gen_column_i;
          file_d  = src_file_i;
          sline_d = src_line_i;
          scol_d  = src_column_i;
          if (start_new_i) begin
            p_gline_d = '0;
            p_gcol_d  = '0;
            p_file_d  = '0;
            p_sline_d = '0;
            p_scol_d  = '0;
            first_d   = 1'b1;
          end
          state_d = smme_pkg::ST_SEP;
        end
      end
      smme_pkg::ST_SEP: begin
        if (diff != '0) begin
          if (!lt) begin
            // line rise: semicolon run
            if (out_free) begin
              emit      = 1'b1;
              ochar_d   = smme_pkg::CHAR_SEMI;
              orep_d    = diff_ext[smme_pkg::REP_BITS-1:0];
              olast_d   = 1'b0;
              p_gline_d = gline_q;
              p_gcol_d  = '0;
              fld_d     = smme_pkg::FLD_GEN_COL;
              state_d   = smme_pkg::ST_LOAD;
            end
          end else begin
            p_gcol_d = '0;
            fld_d    = smme_pkg::FLD_GEN_COL;
            state_d  = smme_pkg::ST_LOAD;
          end
        end else if (!first_q) begin
          if (out_free) begin
            emit    = 1'b1;
            ochar_d = smme_pkg::CHAR_COMMA;
            orep_d  = smme_pkg::REP_BITS'(1);
            olast_d = 1'b0;
            fld_d   = smme_pkg::FLD_GEN_COL;
            state_d = smme_pkg::ST_LOAD;
          end
        end else begin
          fld_d   = smme_pkg::FLD_GEN_COL;
          state_d = smme_pkg::ST_LOAD;
        end
      end
      smme_pkg::ST_LOAD: begin
        load = 1'b1;
        unique case (fld_q)
          smme_pkg::FLD_GEN_COL: p_gcol_d  = gcol_q;
          smme_pkg::FLD_FILE:    p_file_d  = file_q;
          smme_pkg::FLD_SRC_LN:  p_sline_d = sline_q;
          smme_pkg::FLD_SRC_COL: p_scol_d  = scol_q;
          default:               p_gcol_d  = p_gcol_q;
        endcase
        state_d = smme_pkg::ST_EMIT;
      end
      smme_pkg::ST_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          shift   = 1'b1;
          ochar_d = smme_pkg::b64_char(digit);
          orep_d  = smme_pkg::REP_BITS'(1);
          olast_d = 1'b0;
          if (!more) begin
            if (fld_q == smme_pkg::FLD_SRC_COL) begin
              olast_d = 1'b1;
              state_d = smme_pkg::ST_DONE;
            end else begin
              fld_d   = smme_pkg::field_e'(fld_q + 2'd1);
              state_d = smme_pkg::ST_LOAD;
            end
          end
        end
      end
      smme_pkg::ST_DONE: begin
        first_d = 1'b0;
        state_d = smme_pkg::ST_IDLE;
      end
      default: begin
        state_d = smme_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_stall_i) begin
      ovalid_d = ovalid_q;
    end else begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smme_pkg::ST_IDLE;
      fld_q     <= smme_pkg::FLD_GEN_COL;
      p_gline_q <= '0;
      p_gcol_q  <= '0;
      p_file_q  <= '0;
      p_sline_q <= '0;
      p_scol_q  <= '0;
      first_q   <= 1'b1;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      fld_q     <= fld_d;
      p_gline_q <= p_gline_d;
      p_gcol_q  <= p_gcol_d;
      p_file_q  <= p_file_d;
      p_sline_q <= p_sline_d;
      p_scol_q  <= p_scol_d;
      first_q   <= first_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gline_q <= gline_d;
    gcol_q  <= gcol_d;
    file_q  <= file_d;
    sline_q <= sline_d;
    scol_q  <= scol_d;
    ochar_q <= ochar_d;
    orep_q  <= orep_d;
    olast_q <= olast_d;
  end

  assign out_valid_o    = ovalid_q;
  assign out_char_o     = ochar_q;
  assign repeat_count_o = orep_q;
  assign last_char_o    = olast_q;

endmodule

/* dv/tb_source_map_mapping_encoder.sv */
`timescale 1ns / 1ps

module tb_source_map_mapping_encoder;

  localparam int unsigned LINE_W    = 24;
  localparam int unsigned COL_W     = 16;
  localparam int unsigned FILE_BITS = smme_pkg::FILE_BITS;
  localparam int unsigned CHAR_BITS = smme_pkg::CHAR_BITS;
  localparam int unsigned REP_BITS  = smme_pkg::REP_BITS;
  localparam logic [LINE_W-1:0] MAX_LINE = '1;
  localparam logic [COL_W-1:0]  MAX_COL  = '1;
  localparam int SETTLE_CYCLES = 30;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 5;

  typedef struct {
    logic                 start_new;
    logic [LINE_W-1:0]    gen_line;
    logic [COL_W-1:0]     gen_column;
    logic [FILE_BITS-1:0] src_file;
    logic [LINE_W-1:0]    src_line;
    logic [COL_W-1:0]     src_column;
  } mapping_t;

  typedef struct {
    logic [CHAR_BITS-1:0] ch;
    logic [REP_BITS-1:0]  rep;
    logic                 last;
  } text_char_t;

  class MappingTextBoard;
    text_char_t           pending_text[$];
    logic [LINE_W-1:0]    base_gen_line;
    logic [COL_W-1:0]     base_gen_col;
    logic [FILE_BITS-1:0] base_file;
    logic [LINE_W-1:0]    base_src_line;
    logic [COL_W-1:0]     base_src_col;
    bit                   first_open;
    int unsigned          mismatches, mappings, chars_seen, semis, commas, falls;
    string b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    function new();
      restart();
    endfunction

    function void restart();
      base_gen_line = '0;
      base_gen_col  = '0;
      base_file     = '0;
      base_src_line = '0;
      base_src_col  = '0;
      first_open    = 1'b1;
    endfunction

    function int unsigned pending();
      return pending_text.size();
    endfunction

    function void push_char(logic [CHAR_BITS-1:0] ch, logic [REP_BITS-1:0] rep);
      text_char_t t;
      t.ch   = ch;
      t.rep  = rep;
      t.last = 1'b0;
      pending_text = {pending_text, t};
    endfunction

    // zigzag-style sign in bit 0, then 5-bit groups low first, bit 5 = more follows
    function void push_delta(logic [31:0] cur, logic [31:0] prv);
      logic [31:0] v;
      logic [5:0]  digit;
      v = (cur >= prv) ? (cur - prv) << 1 : ((prv - cur) << 1) | 32'd1;
      do begin
        digit = {1'b0, v[4:0]};
        v = v >> 5;
        if (v != 0) digit[5] = 1'b1;
        push_char(CHAR_BITS'(b64_digits[digit]), REP_BITS'(1));
      end while (v != 0);
    endfunction

    function void note_mapping(mapping_t m);
      mappings++;
      if (m.start_new) restart();
      if (m.gen_line != base_gen_line) begin
        base_gen_col = '0;
        if (m.gen_line > base_gen_line) begin
          push_char(smme_pkg::CHAR_SEMI, m.gen_line - base_gen_line);
          base_gen_line = m.gen_line;
          semis++;
        end else begin
          // line went backwards: no separator, old line kept as base
          falls++;
        end
      end else if (!first_open) begin
        push_char(smme_pkg::CHAR_COMMA, REP_BITS'(1));
        commas++;
      end
      push_delta(32'(m.gen_column), 32'(base_gen_col));
      base_gen_col = m.gen_column;
      push_delta(32'(m.src_file), 32'(base_file));
      base_file = m.src_file;
      push_delta(32'(m.src_line), 32'(base_src_line));
      base_src_line = m.src_line;
      push_delta(32'(m.src_column), 32'(base_src_col));
      base_src_col = m.src_column;
      first_open = 1'b0;
      pending_text[pending_text.size()-1].last = 1'b1;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_char(logic [CHAR_BITS-1:0] ch, logic [REP_BITS-1:0] rep, logic last);
      text_char_t want;
      chars_seen++;
      if (pending_text.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h rep %0d", ch, rep));
        return;
      end
      want = pending_text.pop_front();
      if (ch !== want.ch)
        report_mismatch($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
      if (rep !== want.rep)
        report_mismatch($sformatf("repeat %0d, want %0d (char 0x%02h)", rep, want.rep, want.ch));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, want %b (char 0x%02h)", last, want.last, want.ch));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 start_new_i;
  logic [LINE_W-1:0]    gen_line_i;
  logic [COL_W-1:0]     gen_column_i;
  logic [FILE_BITS-1:0] src_file_i;
  logic [LINE_W-1:0]    src_line_i;
  logic [COL_W-1:0]     src_column_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CHAR_BITS-1:0] out_char_o;
  logic [REP_BITS-1:0]  repeat_count_o;
  logic                 last_char_o;

  source_map_mapping_encoder dut (.*);

  MappingTextBoard board = new();

  int gap_max = 0;
  int stall_max = 0;
  int hold_request = 0;
  int holds_done = 0;
  int directed_count = 0;
  int idle_cycles = 0;

  logic [LINE_W-1:0]    walk_line = '0;
  logic [COL_W-1:0]     walk_col = '0;
  logic [FILE_BITS-1:0] walk_file = '0;
  logic [LINE_W-1:0]    walk_src_line = '0;
  logic [COL_W-1:0]     walk_src_col = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // transaction monitor + watchdog
  always @(posedge clk_i) begin : monitor
    mapping_t seen;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        seen.start_new  = start_new_i;
        seen.gen_line   = gen_line_i;
        seen.gen_column = gen_column_i;
        seen.src_file   = src_file_i;
        seen.src_line   = src_line_i;
        seen.src_column = src_column_i;
        board.note_mapping(seen);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_char(out_char_o, repeat_count_o, last_char_o);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d chars outstanding",
                 IDLE_LIMIT, board.pending());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : receiver
    int n;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        holds_done++;
      end else begin
        n = (stall_max == 0) ? 0 : $urandom_range(stall_max);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  function automatic mapping_t mk(logic sn, logic [LINE_W-1:0] gl, logic [COL_W-1:0] gc,
                                  logic [FILE_BITS-1:0] f, logic [LINE_W-1:0] sl,
                                  logic [COL_W-1:0] sc);
    mapping_t m;
    m.start_new  = sn;
    m.gen_line   = gl;
    m.gen_column = gc;
    m.src_file   = f;
    m.src_line   = sl;
    m.src_column = sc;
    return m;
  endfunction

  // mostly plausible compiler output: lines creeping up, columns growing on a line
  function automatic mapping_t draw_mapping();
    mapping_t          m;
    int unsigned       roll;
    logic [31:0]       step;
    logic [LINE_W-1:0] old_line;
    roll = $urandom_range(99);
    if (roll < 12) begin
      m = mk(1'($urandom_range(1)), LINE_W'($urandom), COL_W'($urandom),
             FILE_BITS'($urandom), LINE_W'($urandom), COL_W'($urandom));
      walk_line     = m.gen_line;
      walk_col      = m.gen_column;
      walk_file     = m.src_file;
      walk_src_line = m.src_line;
      walk_src_col  = m.src_column;
      return m;
    end
    m.start_new = ($urandom_range(39) == 0);
    if (m.start_new) begin
      walk_line     = LINE_W'($urandom_range(2));
      walk_col      = '0;
      walk_file     = '0;
      walk_src_line = '0;
      walk_src_col  = '0;
    end
    old_line = walk_line;
    roll = $urandom_range(99);
    if (roll >= 55 && roll < 85) begin
      step = 32'(walk_line) + $urandom_range(1, 3);
      walk_line = (step > 32'(MAX_LINE)) ? MAX_LINE : step[LINE_W-1:0];
    end else if (roll >= 85 && roll < 93) begin
      walk_line = LINE_W'($urandom_range(32'(MAX_LINE), 32'(walk_line)));
    end else if (roll >= 93) begin
      walk_line = LINE_W'($urandom_range(32'(walk_line), 0));
    end
    if (walk_line != old_line) begin
      walk_col = COL_W'($urandom_range(40));
    end else begin
      step = 32'(walk_col) + $urandom_range(30);
      walk_col = (step > 32'(MAX_COL)) ? MAX_COL : step[COL_W-1:0];
    end
    if ($urandom_range(19) == 0) walk_col = COL_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 15) walk_file = FILE_BITS'($urandom_range(7));
    else if (roll < 20) walk_file = FILE_BITS'($urandom);
    roll = $urandom_range(99);
    if (roll < 60) begin
      step = 32'(walk_src_line) + $urandom_range(3);
      walk_src_line = (step > 32'(MAX_LINE)) ? MAX_LINE : step[LINE_W-1:0];
    end else if (roll < 90) begin
      walk_src_line = (walk_src_line > 5) ? walk_src_line - LINE_W'($urandom_range(5)) : '0;
    end else begin
      walk_src_line = LINE_W'($urandom);
    end
    walk_src_col = ($urandom_range(9) == 0) ? COL_W'($urandom) : COL_W'($urandom_range(80));
    m.gen_line   = walk_line;
    m.gen_column = walk_col;
    m.src_file   = walk_file;
    m.src_line   = walk_src_line;
    m.src_column = walk_src_col;
    return m;
  endfunction

  // called and returns at a falling edge
  task automatic send_mapping(mapping_t m);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_new_i  <= m.start_new;
    gen_line_i   <= m.gen_line;
    gen_column_i <= m.gen_column;
    src_file_i   <= m.src_file;
    src_line_i   <= m.src_line;
    src_column_i <= m.src_column;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_directed(mapping_t m);
    directed_count++;
    send_mapping(m);
  endtask

  int phase_items[PHASES] = '{60, 90, 80, 80, 150};
  int phase_gap[PHASES]   = '{0, 12, 0, 12, 5};
  int phase_stall[PHASES] = '{0, 12, 12, 0, 5};

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_stall_i  = 1'b0;
    start_new_i  = 1'b0;
    gen_line_i   = '0;
    gen_column_i = '0;
    src_file_i   = '0;
    src_line_i   = '0;
    src_column_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    gap_max   = 3;
    stall_max = 3;
    send_directed(mk(1'b0, '0, '0, '0, '0, '0));                     // first on line 0, no comma
    send_directed(mk(1'b0, '0, MAX_COL, '1, MAX_LINE, MAX_COL));     // biggest positive deltas
    send_directed(mk(1'b0, '0, '0, '0, '0, '0));                     // biggest negative deltas
    send_directed(mk(1'b0, MAX_LINE, MAX_COL, '1, MAX_LINE, MAX_COL)); // longest semicolon run
    send_directed(mk(1'b0, 24'd5, 16'd100, 10'd3, 24'd10, 16'd7));   // line falls
    send_directed(mk(1'b0, 24'd5, 16'd200, 10'd3, 24'd10, 16'd7));   // still below kept line
    send_directed(mk(1'b1, '0, '0, '0, '0, '0));                     // restart on line 0
    send_directed(mk(1'b0, '0, 16'd15, '0, '0, '0));                 // one-digit VLQ edge
    send_directed(mk(1'b0, '0, 16'd31, '0, '0, '0));                 // first two-digit VLQ
    send_directed(mk(1'b1, 24'd3, 16'd1, 10'd1, 24'd1, 16'd1));      // restart with a rise
    send_directed(mk(1'b0, 24'd4, '0, '0, '0, '0));
    send_directed(mk(1'b0, 24'd4, 16'hAAAA, 10'h2AA, 24'hAAAAAA, 16'h5555));
    send_directed(mk(1'b0, 24'd4, 16'h5555, 10'h155, 24'h555555, 16'hAAAA));
    send_directed(mk(1'b0, 24'hFFFFFE, '0, '0, '0, '0));
    send_directed(mk(1'b0, MAX_LINE, MAX_COL, '1, '0, MAX_COL));
    send_directed(mk(1'b0, MAX_LINE, '0, '0, MAX_LINE, '0));
    send_directed(mk(1'b1, MAX_LINE, MAX_COL, '1, MAX_LINE, MAX_COL));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      stall_max = phase_stall[p];
      if (p == 3) begin
        // receiver sits on its stall while input keeps coming, block backs up
        gap_max = 0;
        hold_request = HOLD_CYCLES;
        repeat (40) send_mapping(draw_mapping());
      end
      gap_max = phase_gap[p];
      repeat (phase_items[p]) send_mapping(draw_mapping());
      if (p == 3) settle();
    end
    settle();

    $display("Ran %0d mappings (%0d directed), checked %0d output chars.",
             board.mappings, directed_count, board.chars_seen);
    $display("Saw %0d semicolon runs, %0d commas, %0d line falls, %0d long receiver holds.",
             board.semis, board.commas, board.falls, holds_done);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
